// ===== rtl/bcec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcec_pkg: shared types and codes for the button click event classifier
// Payload structs, register defaults and indexes, event and phase codes.
// ----------------------------------------------------------------------------
package bcec_pkg;

  localparam int unsigned KEYS       = 4;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned EVENT_W    = 3;
  localparam int unsigned CFG_ADDR_W = 3;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SHORT_PRESS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CLICK_GAP   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD        = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_CAP = 3'd4;

  // Register reset values
  localparam logic [CFG_W-1:0] SHORT_PRESS_RST = 16'd300;
  localparam logic [CFG_W-1:0] CLICK_GAP_RST   = 16'd120;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 16'd500;
  localparam logic [CFG_W-1:0] HOLD_RST        = 16'd3000;
  localparam logic [CFG_W-1:0] RELEASE_CAP_RST = 16'd65000;

  // Event codes
  localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
  localparam logic [EVENT_W-1:0] EV_SHORT  = 3'd1;
  localparam logic [EVENT_W-1:0] EV_LONG   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_HOLD   = 3'd3;
  localparam logic [EVENT_W-1:0] EV_DOUBLE = 3'd4;
  localparam logic [EVENT_W-1:0] EV_TRIPLE = 3'd5;

  // Key phase codes
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_PRESSED  = 2'd1;
  localparam logic [1:0] PH_RELEASED = 2'd2;

  // Debounce history patterns
  localparam logic [7:0] HIST_PRESS   = 8'hF0;
  localparam logic [7:0] HIST_RELEASE = 8'h0F;

  typedef struct packed {
    logic [KEYS-1:0] key_levels;
    logic [KEYS-1:0] clear_mask;
  } in_item_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_key0;
    logic [EVENT_W-1:0] event_key1;
    logic [EVENT_W-1:0] event_key2;
    logic [EVENT_W-1:0] event_key3;
    logic [KEYS-1:0]    pressed_mask;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] short_press_limit;
    logic [CFG_W-1:0] click_gap_limit;
    logic [CFG_W-1:0] long_press_limit;
    logic [CFG_W-1:0] hold_limit;
    logic [CFG_W-1:0] release_count_cap;
  } cfg_regs_t;

  // What one key lane reports for the current tick
  typedef struct packed {
    logic [EVENT_W-1:0] event_code;
    logic               pressed;
  } lane_res_t;

endpackage

// ===== rtl/bcec_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcec_lane: per-key click/press tracker
// Holds one key's history, phase, counters and pending event; advances on
// each accepted tick and reports the post-tick event and pressed state.
// ----------------------------------------------------------------------------
module bcec_lane #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  tick,
  input  logic                  level,
  input  logic                  clear,
  input  bcec_pkg::cfg_regs_t   cfg,
  output bcec_pkg::lane_res_t   res
);

  localparam int unsigned CW    = COUNTER_WIDTH;
  localparam int unsigned CMP_W = (CW > bcec_pkg::CFG_W) ? CW : bcec_pkg::CFG_W;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};

  logic [7:0]                     hist_r, hist_nxt;
  logic [1:0]                     phase_r, phase_nxt;
  logic [CW-1:0]                  hold_r, hold_nxt;
  logic [CW-1:0]                  rel_r, rel_nxt;
  logic [CW-1:0]                  last_r, last_nxt;
  logic [CW-1:0]                  newer_r, newer_nxt;
  logic [CW-1:0]                  older_r, older_nxt;
  logic [bcec_pkg::EVENT_W-1:0]   ev_r, ev_nxt;

  logic [CMP_W-1:0] h_x, g1_x, g0_x, hold_x, rel_x;
  logic [CMP_W-1:0] sp_x, gap_x, lp_x, hl_x, cap_x, rel_inc_x;
  logic [CW-1:0]    rel_inc;
  logic [bcec_pkg::EVENT_W-1:0] ev_held, ev_class;
  logic press, release_edge, classify;

  always_comb begin
    h_x    = CMP_W'(last_r);
    g1_x   = CMP_W'(newer_r);
    g0_x   = CMP_W'(older_r);
    hold_x = CMP_W'(hold_r);
    rel_x  = CMP_W'(rel_r);
    sp_x   = CMP_W'(cfg.short_press_limit);
    gap_x  = CMP_W'(cfg.click_gap_limit);
    lp_x   = CMP_W'(cfg.long_press_limit);
    hl_x   = CMP_W'(cfg.hold_limit);
    cap_x  = CMP_W'(cfg.release_count_cap);

    // clear first, then the continuous hold check
    ev_held = clear ? bcec_pkg::EV_NONE : ev_r;
    if (hold_x > hl_x) begin
      ev_held = bcec_pkg::EV_HOLD;
    end

    // later rules take priority
    ev_class = bcec_pkg::EV_NONE;
    if ((h_x != '0) && (h_x < sp_x)) begin
      ev_class = bcec_pkg::EV_SHORT;
    end
    if ((g1_x != '0) && (g1_x < gap_x)) begin
      ev_class = bcec_pkg::EV_DOUBLE;
    end
    if ((g1_x != '0) && (g1_x < gap_x) && (g0_x < gap_x)) begin
      ev_class = bcec_pkg::EV_TRIPLE;
    end
    if ((h_x > lp_x) && (h_x < hl_x)) begin
      ev_class = bcec_pkg::EV_LONG;
    end

    classify = (rel_x == gap_x);
    ev_nxt   = (classify && (ev_held == bcec_pkg::EV_NONE)) ? ev_class : ev_held;

    hist_nxt     = {hist_r[6:0], level};
    press        = (hist_nxt == bcec_pkg::HIST_PRESS);
    release_edge = (hist_nxt == bcec_pkg::HIST_RELEASE);

    phase_nxt = phase_r;
    older_nxt = older_r;
    newer_nxt = newer_r;
    last_nxt  = classify ? '0 : last_r;
    if (press) begin
      phase_nxt = bcec_pkg::PH_PRESSED;
      older_nxt = newer_r;
      newer_nxt = rel_r;
    end
    if (release_edge) begin
      phase_nxt = bcec_pkg::PH_RELEASED;
      last_nxt  = hold_r;
    end

    rel_inc   = (rel_r != CMAX) ? rel_r + 1'b1 : rel_r;
    rel_inc_x = CMP_W'(rel_inc);

    hold_nxt = hold_r;
    if (release_edge) begin
      hold_nxt = '0;
    end else if (phase_nxt == bcec_pkg::PH_PRESSED) begin
      hold_nxt = (hold_r != CMAX) ? hold_r + 1'b1 : hold_r;
    end

    rel_nxt = rel_r;
    if (press) begin
      rel_nxt = '0;
    end else if (phase_nxt == bcec_pkg::PH_RELEASED) begin
      rel_nxt = (rel_inc_x > cap_x) ? CW'(cfg.release_count_cap) : rel_inc;
    end

    res.event_code = ev_nxt;
    res.pressed    = (phase_nxt == bcec_pkg::PH_PRESSED);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= '0;
      phase_r <= bcec_pkg::PH_IDLE;
      hold_r  <= '0;
      rel_r   <= '0;
      last_r  <= '0;
      newer_r <= '0;
      older_r <= '0;
      ev_r    <= bcec_pkg::EV_NONE;
    end else if (tick) begin
      hist_r  <= hist_nxt;
      phase_r <= phase_nxt;
      hold_r  <= hold_nxt;
      rel_r   <= rel_nxt;
      last_r  <= last_nxt;
      newer_r <= newer_nxt;
      older_r <= older_nxt;
      ev_r    <= ev_nxt;
    end
  end

endmodule

// ===== rtl/bcec_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcec_merge: lane merge and output register
// Packs the per-key lane reports into one result and holds it until the
// downstream side takes the transfer.
// ----------------------------------------------------------------------------
module bcec_merge (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  bcec_pkg::lane_res_t [bcec_pkg::KEYS-1:0]  lane_res,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output bcec_pkg::out_item_t                       out_data
);

  logic                valid_r, valid_nxt;
  bcec_pkg::out_item_t data_r, data_nxt;
  logic                take;

  assign in_stall = valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  always_comb begin
    data_nxt.event_key0 = lane_res[0].event_code;
    data_nxt.event_key1 = lane_res[1].event_code;
    data_nxt.event_key2 = lane_res[2].event_code;
    data_nxt.event_key3 = lane_res[3].event_code;
    for (int k = 0; k < bcec_pkg::KEYS; k++) begin
      data_nxt.pressed_mask[k] = lane_res[k].pressed;
    end
    valid_nxt = take ? 1'b1 : (valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== rtl/button_click_event_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_event_classifier: multi-click and long-press detector
// Debounces up to four keys and reports per-key click events every tick.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transfer (in_valid high, in_stall low) is one 1 ms tick with
//   the raw key levels and a mask that clears pending events first.
//   Every tick yields exactly one result transfer on out_*: the pending
//   event of each key (none/short/long/hold/double/triple) and a mask of
//   keys currently in the pressed phase.
//   Latency: the result is registered, out_valid rises the cycle after the
//   input transfer. Throughput: one tick per cycle while out_stall is low;
//   each key lane does its compares and counter updates combinationally.
//   Stall: one output register; while it is full and out_stall is high,
//   in_stall is raised and no tick is taken. Otherwise a new tick is taken
//   in the same cycle the previous result leaves.
//   Config: cfg_we writes cfg_wdata to register cfg_addr (0 short press,
//   1 click gap, 2 long press, 3 hold, 4 release cap); other indexes are
//   dropped. Write only while idle.
//   Reset (rst_n low, synchronous): all key state clears to idle/zero,
//   registers return to 300/120/500/3000/65000, the output empties.
//   Keys at or above KEY_COUNT report no event and never show pressed.
// ----------------------------------------------------------------------------
module button_click_event_classifier #(
  parameter int unsigned KEY_COUNT     = 4,
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bcec_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bcec_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [bcec_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bcec_pkg::CFG_W-1:0]         cfg_wdata
);

  bcec_pkg::cfg_regs_t                      cfg_r, cfg_nxt;
  bcec_pkg::lane_res_t [bcec_pkg::KEYS-1:0] lane_res;
  logic                                     tick;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        bcec_pkg::REG_SHORT_PRESS: cfg_nxt.short_press_limit = cfg_wdata;
        bcec_pkg::REG_CLICK_GAP:   cfg_nxt.click_gap_limit   = cfg_wdata;
        bcec_pkg::REG_LONG_PRESS:  cfg_nxt.long_press_limit  = cfg_wdata;
        bcec_pkg::REG_HOLD:        cfg_nxt.hold_limit        = cfg_wdata;
        bcec_pkg::REG_RELEASE_CAP: cfg_nxt.release_count_cap = cfg_wdata;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_press_limit <= bcec_pkg::SHORT_PRESS_RST;
      cfg_r.click_gap_limit   <= bcec_pkg::CLICK_GAP_RST;
      cfg_r.long_press_limit  <= bcec_pkg::LONG_PRESS_RST;
      cfg_r.hold_limit        <= bcec_pkg::HOLD_RST;
      cfg_r.release_count_cap <= bcec_pkg::RELEASE_CAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // A tick advances every lane when the input transfer happens
  assign tick = in_valid && !in_stall;

  // One lane per configured key; unused key slots report nothing
  for (genvar k = 0; k < bcec_pkg::KEYS; k++) begin : g_key
    if (k < KEY_COUNT) begin : g_lane
      bcec_lane #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
      ) u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick),
        .level (in_data.key_levels[k]),
        .clear (in_data.clear_mask[k]),
        .cfg   (cfg_r),
        .res   (lane_res[k])
      );
    end else begin : g_unused
      assign lane_res[k] = '0;
    end
  end

  // Merge lane reports into the registered result
  bcec_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .lane_res  (lane_res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for button_click_event_classifier
// Drives 1 ms key ticks through the valid/stall input channel. A tracker
// class mirrors every key's history, phase and counters to predict the event
// word of each tick. Every output transfer is checked field by field against
// the oldest prediction. Register settings change only while the block is
// idle. Both sides idle at random in the earlier phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CNT_W        = 16;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned PHASE_TICKS  = 140;
  // long enough to cross the hold limit and park the release counter
  localparam int unsigned SAT_TICKS    = 40;
  localparam logic [bcec_pkg::CFG_ADDR_W-1:0] REG_UNUSED_FIRST =
    bcec_pkg::REG_RELEASE_CAP + 1'b1;

  // Per-key behavioral mirror plus the queue of predicted event words.
  class key_event_tracker;
    logic [bcec_pkg::CFG_W-1:0]   short_lim, gap_lim, long_lim, hold_lim, rel_cap;
    logic [7:0]                   hist      [bcec_pkg::KEYS];
    logic [1:0]                   phase     [bcec_pkg::KEYS];
    logic [CNT_W-1:0]             hold_cnt  [bcec_pkg::KEYS];
    logic [CNT_W-1:0]             rel_cnt   [bcec_pkg::KEYS];
    logic [CNT_W-1:0]             last_hold [bcec_pkg::KEYS];
    logic [CNT_W-1:0]             gap_new   [bcec_pkg::KEYS];
    logic [CNT_W-1:0]             gap_old   [bcec_pkg::KEYS];
    logic [bcec_pkg::EVENT_W-1:0] pend      [bcec_pkg::KEYS];
    bcec_pkg::out_item_t          expected_events [$];
    int unsigned                  mismatches;

    function new();
      int k;
      short_lim = bcec_pkg::SHORT_PRESS_RST;
      gap_lim   = bcec_pkg::CLICK_GAP_RST;
      long_lim  = bcec_pkg::LONG_PRESS_RST;
      hold_lim  = bcec_pkg::HOLD_RST;
      rel_cap   = bcec_pkg::RELEASE_CAP_RST;
      for (k = 0; k < bcec_pkg::KEYS; k++) begin
        hist[k]      = '0;
        phase[k]     = bcec_pkg::PH_IDLE;
        hold_cnt[k]  = '0;
        rel_cnt[k]   = '0;
        last_hold[k] = '0;
        gap_new[k]   = '0;
        gap_old[k]   = '0;
        pend[k]      = bcec_pkg::EV_NONE;
      end
      mismatches = 0;
    endfunction

    // Indexes past the last register are dropped, same as the block.
    function void write_reg(logic [bcec_pkg::CFG_ADDR_W-1:0] addr,
                            logic [bcec_pkg::CFG_W-1:0] val);
      case (addr)
        bcec_pkg::REG_SHORT_PRESS: short_lim = val;
        bcec_pkg::REG_CLICK_GAP:   gap_lim   = val;
        bcec_pkg::REG_LONG_PRESS:  long_lim  = val;
        bcec_pkg::REG_HOLD:        hold_lim  = val;
        bcec_pkg::REG_RELEASE_CAP: rel_cap   = val;
        default: ;
      endcase
    endfunction

    // One accepted tick: event judgment, edge detection, then counting.
    function void take_tick(bcec_pkg::in_item_t it);
      int k;
      logic [bcec_pkg::EVENT_W-1:0] ev;
      logic [bcec_pkg::KEYS-1:0]    pressed;
      bcec_pkg::out_item_t          word;
      pressed = '0;
      for (k = 0; k < bcec_pkg::KEYS; k++) begin
        if (it.clear_mask[k]) pend[k] = bcec_pkg::EV_NONE;
        if (hold_cnt[k] > hold_lim) pend[k] = bcec_pkg::EV_HOLD;
        if (rel_cnt[k] == gap_lim) begin
          // later rules win; an event already pending is left alone
          if (pend[k] == bcec_pkg::EV_NONE) begin
            ev = bcec_pkg::EV_NONE;
            if (last_hold[k] > 0 && last_hold[k] < short_lim) ev = bcec_pkg::EV_SHORT;
            if (gap_new[k] > 0 && gap_new[k] < gap_lim) ev = bcec_pkg::EV_DOUBLE;
            if (gap_new[k] > 0 && gap_new[k] < gap_lim && gap_old[k] < gap_lim)
              ev = bcec_pkg::EV_TRIPLE;
            if (last_hold[k] > long_lim && last_hold[k] < hold_lim) ev = bcec_pkg::EV_LONG;
            pend[k] = ev;
          end
          last_hold[k] = '0;
        end
        hist[k] = {hist[k][6:0], it.key_levels[k]};
        if (hist[k] == bcec_pkg::HIST_PRESS) begin
          phase[k]   = bcec_pkg::PH_PRESSED;
          gap_old[k] = gap_new[k];
          gap_new[k] = rel_cnt[k];
          rel_cnt[k] = '0;
        end
        if (hist[k] == bcec_pkg::HIST_RELEASE) begin
          phase[k]     = bcec_pkg::PH_RELEASED;
          last_hold[k] = hold_cnt[k];
          hold_cnt[k]  = '0;
        end
        if (phase[k] == bcec_pkg::PH_PRESSED) begin
          if (hold_cnt[k] != '1) hold_cnt[k] = hold_cnt[k] + 1'b1;
          pressed[k] = 1'b1;
        end else if (phase[k] == bcec_pkg::PH_RELEASED) begin
          if (rel_cnt[k] != '1) rel_cnt[k] = rel_cnt[k] + 1'b1;
          if (rel_cnt[k] > rel_cap) rel_cnt[k] = rel_cap;
        end
      end
      word = '{event_key0: pend[0], event_key1: pend[1], event_key2: pend[2],
               event_key3: pend[3], pressed_mask: pressed};
      expected_events.push_back(word);
    endfunction

    function void match_result(bcec_pkg::out_item_t got);
      int k;
      bcec_pkg::out_item_t          want;
      logic [bcec_pkg::EVENT_W-1:0] want_ev [bcec_pkg::KEYS];
      logic [bcec_pkg::EVENT_W-1:0] got_ev  [bcec_pkg::KEYS];
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result transfer %h", $time, got);
        mismatches++;
        return;
      end
      want    = expected_events.pop_front();
      want_ev = '{want.event_key0, want.event_key1, want.event_key2, want.event_key3};
      got_ev  = '{got.event_key0, got.event_key1, got.event_key2, got.event_key3};
      for (k = 0; k < bcec_pkg::KEYS; k++) begin
        if (got_ev[k] !== want_ev[k]) begin
          $display("%0t: key %0d event expected %0d actual %0d",
                   $time, k, want_ev[k], got_ev[k]);
          mismatches++;
        end
      end
      if (got.pressed_mask !== want.pressed_mask) begin
        $display("%0t: pressed_mask expected %b actual %b",
                 $time, want.pressed_mask, got.pressed_mask);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_events.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  bcec_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_stall;
  bcec_pkg::out_item_t             out_data;
  logic                            cfg_we;
  logic [bcec_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [bcec_pkg::CFG_W-1:0]      cfg_wdata;

  key_event_tracker tracker = new();

  // Key waveform generator: each key holds a level for a random run, then
  // flips. Runs of 1..3 ticks act as contact bounce and never form an edge.
  logic [bcec_pkg::KEYS-1:0] key_lvl;
  int unsigned     run_left [bcec_pkg::KEYS];
  int unsigned     lo_max = 60;   // longest low run (hold length)
  int unsigned     hi_max = 60;   // longest high run (release gap)
  int unsigned     send_pct;      // chance in 100 that the sender idles a cycle
  int unsigned     recv_pct;      // chance in 100 that the receiver stalls
  int unsigned     cycle_count = 0;

  button_click_event_classifier u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_pct);
  end

  // Output side: every transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid && !out_stall) tracker.match_result(out_data);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  function bcec_pkg::in_item_t next_tick();
    int k;
    bcec_pkg::in_item_t it;
    for (k = 0; k < bcec_pkg::KEYS; k++) begin
      if (run_left[k] == 0) begin
        key_lvl[k] = ~key_lvl[k];
        if ($urandom_range(0, 7) == 0) run_left[k] = $urandom_range(1, 3);
        else if (key_lvl[k])          run_left[k] = $urandom_range(4, hi_max);
        else                          run_left[k] = $urandom_range(4, lo_max);
      end
      run_left[k]--;
      it.clear_mask[k] = ($urandom_range(0, 7) == 0);
    end
    it.key_levels = key_lvl;
    return it;
  endfunction

  // One input transfer. Valid is lowered only for idle cycles, so a
  // back-to-back tick keeps valid high without a second assignment.
  task send_tick(input bcec_pkg::in_item_t it);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_tick(it);
  endtask

  // Drain, then write all five registers plus one unused index.
  task program_regs(input logic [bcec_pkg::CFG_W-1:0] sp,
                    input logic [bcec_pkg::CFG_W-1:0] gp,
                    input logic [bcec_pkg::CFG_W-1:0] lp,
                    input logic [bcec_pkg::CFG_W-1:0] hl,
                    input logic [bcec_pkg::CFG_W-1:0] cap);
    logic [bcec_pkg::CFG_W-1:0]      vals  [5];
    logic [bcec_pkg::CFG_ADDR_W-1:0] addrs [5];
    logic [bcec_pkg::CFG_ADDR_W-1:0] junk_addr;
    logic [bcec_pkg::CFG_W-1:0]      junk_data;
    int i;
    vals  = '{sp, gp, lp, hl, cap};
    addrs = '{bcec_pkg::REG_SHORT_PRESS, bcec_pkg::REG_CLICK_GAP, bcec_pkg::REG_LONG_PRESS,
              bcec_pkg::REG_HOLD, bcec_pkg::REG_RELEASE_CAP};
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);   // output register is one stage deep
    for (i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= addrs[i];
      cfg_wdata <= vals[i];
      tracker.write_reg(addrs[i], vals[i]);
      @(posedge clk);
    end
    junk_addr = bcec_pkg::CFG_ADDR_W'($urandom_range(int'(REG_UNUSED_FIRST),
                                                     2**bcec_pkg::CFG_ADDR_W - 1));
    junk_data = bcec_pkg::CFG_W'($urandom());
    cfg_addr  <= junk_addr;
    cfg_wdata <= junk_data;
    tracker.write_reg(junk_addr, junk_data);
    @(posedge clk);
    cfg_we <= 1'b0;
    // scale key runs so holds and gaps straddle the new limits
    lo_max = (hl < 100) ? hl + 10 : 60;
    hi_max = (gp < 100) ? 2 * gp + 10 : 60;
  endtask

  task run_random(input int unsigned n);
    repeat (n) send_tick(next_tick());
  endtask

  initial begin
    int i;
    int unsigned t;
    bcec_pkg::in_item_t it;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= bcec_pkg::REG_SHORT_PRESS;
    cfg_wdata <= '0;
    key_lvl = '1;
    for (i = 0; i < bcec_pkg::KEYS; i++) run_left[i] = 8;
    send_pct = 38;
    recv_pct = 75;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset register values: all keys released, then all pressed
    // with clears toggling, then level patterns 0 to 7 against their inverse masks.
    for (i = 0; i < 8; i++) send_tick('{key_levels: 4'hF, clear_mask: 4'h0});
    for (i = 0; i < 8; i++) send_tick('{key_levels: 4'h0, clear_mask: i[0] ? 4'hF : 4'h0});
    for (i = 0; i < 8; i++) send_tick('{key_levels: 4'(i), clear_mask: 4'(15 - i)});

    // Tight limits, release cap at its top value.
    program_regs(16'd6, 16'd5, 16'd12, 16'd20, 16'hFFFF);
    run_random(PHASE_TICKS);
    // Release cap equal to the click gap: counter parks there, classify each tick.
    program_regs(16'd10, 16'd8, 16'd15, 16'd30, 16'd8);
    run_random(PHASE_TICKS);

    send_pct = 75;
    recv_pct = 38;
    // Everything zero: hold event on any held key, classify while idle.
    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(PHASE_TICKS);
    program_regs(bcec_pkg::CFG_W'($urandom_range(0, 20)),
                 bcec_pkg::CFG_W'($urandom_range(0, 20)),
                 bcec_pkg::CFG_W'($urandom_range(0, 30)),
                 bcec_pkg::CFG_W'($urandom_range(0, 50)),
                 bcec_pkg::CFG_W'($urandom_range(0, 40)));
    run_random(PHASE_TICKS);

    send_pct = 0;
    recv_pct = 0;
    // Top-end limits: every real hold is both short and long.
    program_regs(16'hFFFF, 16'd12, 16'd0, 16'hFFFF, 16'hFFFF);
    run_random(PHASE_TICKS);
    program_regs(bcec_pkg::CFG_W'($urandom_range(0, 20)),
                 bcec_pkg::CFG_W'($urandom_range(1, 20)),
                 bcec_pkg::CFG_W'($urandom_range(0, 30)),
                 bcec_pkg::CFG_W'($urandom_range(0, 50)),
                 bcec_pkg::CFG_W'($urandom_range(0, 40)));
    run_random(PHASE_TICKS);

    // Key 0 held past the hold limit, then released; with the release cap
    // equal to the click gap the parked release counter classifies on every
    // tick.
    program_regs(16'd200, 16'd30, 16'd10, 16'd20, 16'd30);
    for (t = 0; t < 8 + 2 * SAT_TICKS; t++) begin
      it = next_tick();
      it.key_levels[0] = (t < 8 || t >= 8 + SAT_TICKS);
      send_tick(it);
    end

    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
